[src/cdq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the circular deque core.
// Used by cdq_ctrl, cdq_datapath and circular_deque_core; no dependencies.
package cdq_pkg;

   localparam int SLOTS   = 16;
   localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int VALUE_W = 32;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [VALUE_W-1:0] value_type;

   typedef enum logic [1:0] {
      FUNC_PUSH_FRONT = 2'd0,
      FUNC_PUSH_BACK  = 2'd1,
      FUNC_DROP_FRONT = 2'd2,
      FUNC_DROP_BACK  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_LOAD
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic exec;
      logic read;
      logic load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic rsp_busy;
   } stat_type;

   localparam idx_type LAST_IDX = idx_type'(SLOTS - 1);

   function automatic idx_type wrap_inc(input idx_type i);
      return (i == LAST_IDX) ? '0 : idx_type'(i + 1'b1);
   endfunction

   function automatic idx_type wrap_dec(input idx_type i);
      return (i == '0) ? LAST_IDX : idx_type'(i - 1'b1);
   endfunction

endpackage

[src/cdq_ctrl.sv]
`timescale 1ns / 1ps
// Sequencing state machine for the circular deque core.
// Depends on cdq_pkg for the state, command and status types.
module cdq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  cdq_pkg::stat_type stat,
   output cdq_pkg::cmd_type  cmd
);

   cdq_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cdq_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = cdq_pkg::ST_EXEC;
         end
         cdq_pkg::ST_EXEC: state_in = cdq_pkg::ST_READ;
         cdq_pkg::ST_READ: state_in = cdq_pkg::ST_LOAD;
         cdq_pkg::ST_LOAD: begin
            if (!stat.rsp_busy) state_in = cdq_pkg::ST_IDLE;
         end
         default: state_in = cdq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      cmd         = '0;
      case (state_ff)
         cdq_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         cdq_pkg::ST_EXEC: cmd.exec = 1'b1;
         cdq_pkg::ST_READ: cmd.read = 1'b1;
         cdq_pkg::ST_LOAD: cmd.load = !stat.rsp_busy;
         default: cmd = '0;
      endcase
   end

endmodule

[src/cdq_datapath.sv]
`timescale 1ns / 1ps
// Pointers, slot memory and result register of the circular deque core.
// Depends on cdq_pkg; driven by the commands of cdq_ctrl.
module cdq_datapath (
   input  logic               clock,
   input  logic               reset,
   input  cdq_pkg::cmd_type   cmd,
   output cdq_pkg::stat_type  stat,
   input  logic [1:0]         req_func,
   input  cdq_pkg::value_type req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output cdq_pkg::value_type rsp_front_value,
   output cdq_pkg::value_type rsp_back_value,
   output logic               rsp_is_empty,
   output logic               rsp_is_full
);

   cdq_pkg::value_type slot_mem [cdq_pkg::SLOTS];

   cdq_pkg::func_type   func_ff;
   cdq_pkg::value_type  value_ff;
   cdq_pkg::idx_type    front_ff, front_in;
   cdq_pkg::idx_type    back_ff, back_in;
   cdq_pkg::status_type status_ff, status_in;
   cdq_pkg::value_type  rd_front_ff, rd_back_ff;
   logic                empty_ff, full_ff;
   logic                rsp_valid_ff;
   logic [1:0]          rsp_status_ff;
   cdq_pkg::value_type  rsp_front_ff, rsp_back_ff;
   logic                rsp_empty_ff, rsp_full_ff;

   logic                is_empty_now, is_full_now;
   logic                wr_en;
   cdq_pkg::idx_type    wr_idx;

   assign is_empty_now = (front_ff == back_ff);
   assign is_full_now  = (cdq_pkg::wrap_inc(back_ff) == front_ff);

   always_comb begin
      front_in  = front_ff;
      back_in   = back_ff;
      status_in = cdq_pkg::STATUS_DONE;
      wr_en     = 1'b0;
      wr_idx    = back_ff;
      case (func_ff)
         cdq_pkg::FUNC_PUSH_FRONT: begin
            if (is_full_now) begin
               status_in = cdq_pkg::STATUS_FULL;
            end else begin
               front_in = cdq_pkg::wrap_dec(front_ff);
               wr_idx   = front_in;
               wr_en    = 1'b1;
            end
         end
         cdq_pkg::FUNC_PUSH_BACK: begin
            if (is_full_now) begin
               status_in = cdq_pkg::STATUS_FULL;
            end else begin
               wr_idx  = back_ff;
               wr_en   = 1'b1;
               back_in = cdq_pkg::wrap_inc(back_ff);
            end
         end
         cdq_pkg::FUNC_DROP_FRONT: begin
            if (is_empty_now) status_in = cdq_pkg::STATUS_EMPTY;
            else front_in = cdq_pkg::wrap_inc(front_ff);
         end
         default: begin
            if (is_empty_now) status_in = cdq_pkg::STATUS_EMPTY;
            else back_in = cdq_pkg::wrap_dec(back_ff);
         end
      endcase
   end

   // Pointers and the response valid flag are control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         back_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.exec) begin
            front_ff <= front_in;
            back_ff  <= back_in;
         end
         if (cmd.load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= cdq_pkg::func_type'(req_func);
         value_ff <= req_value;
      end
      if (cmd.exec) status_ff <= status_in;
      if (cmd.load) begin
         rsp_status_ff <= status_ff;
         rsp_front_ff  <= empty_ff ? '1 : rd_front_ff;
         rsp_back_ff   <= empty_ff ? '1 : rd_back_ff;
         rsp_empty_ff  <= empty_ff;
         rsp_full_ff   <= full_ff;
      end
   end

   // Slot memory: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (cmd.exec && wr_en) slot_mem[wr_idx] <= value_ff;
      if (cmd.read) begin
         rd_front_ff <= slot_mem[front_ff];
         rd_back_ff  <= slot_mem[cdq_pkg::wrap_dec(back_ff)];
         empty_ff    <= is_empty_now;
         full_ff     <= is_full_now;
      end
   end

   assign stat.rsp_busy   = rsp_valid_ff && !rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_back_value  = rsp_back_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;

endmodule

[src/circular_deque_core.sv]
`timescale 1ns / 1ps
// Top level of the circular deque core: stream ports around the controller and datapath.
// Depends on cdq_pkg, cdq_ctrl and cdq_datapath.
//
// A double-ended queue of up to SLOTS-1 signed 32-bit values kept in a ring of
// SLOTS entries (SLOTS is set in cdq_pkg). Each input item carries an operation in
// req_tuser (push front, push back, drop front, drop back) and a value in req_tdata.
// Every item yields one result item with a status code in rsp_tuser (done, refused
// because full, refused because empty) and, in rsp_tdata, the front and back values
// after the operation (all ones when empty) and the empty and full flags. An item is
// captured when it is accepted; the pointer update with the memory write, the
// registered two-port memory read and the result load follow in that order, the
// load waiting while an earlier result is still held. The result sits in an output
// register, so the next item is accepted while it waits; a new item is taken only
// after the result of the last one is loaded. No clearing pass is needed after reset.
module circular_deque_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [1:0]  req_tuser,   // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] front_value, [63:32] back_value,
                                    // [64] is_empty, [65] is_full, [71:66] zero
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   cdq_pkg::cmd_type   cmd;
   cdq_pkg::stat_type  stat;
   cdq_pkg::value_type front_value, back_value;
   logic               is_empty, is_full;

   cdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   cdq_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_func        (req_tuser),
      .req_value       (req_tdata),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_status      (rsp_tuser),
      .rsp_front_value (front_value),
      .rsp_back_value  (back_value),
      .rsp_is_empty    (is_empty),
      .rsp_is_full     (is_full)
   );

   assign rsp_tdata = {6'd0, is_full, is_empty, back_value, front_value};

endmodule
